FILE: rtl/core/presence_aged_house_aggregator_top_defines.svh
// Assertion macros shared by the aggregator RTL.
`ifndef PRESENCE_AGED_HOUSE_AGGREGATOR_TOP_DEFINES_SVH
`define PRESENCE_AGED_HOUSE_AGGREGATOR_TOP_DEFINES_SVH

`ifndef SYNTHESIS
// Same-cycle implication, disabled during reset.
`define PAHAG_ASSERT_IMPL(label, clk, rst, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error("assertion failed");
// Next-cycle implication, disabled during reset.
`define PAHAG_ASSERT_NEXT(label, clk, rst, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error("assertion failed");
`else
`define PAHAG_ASSERT_IMPL(label, clk, rst, ante, cons)
`define PAHAG_ASSERT_NEXT(label, clk, rst, ante, cons)
`endif

`endif

FILE: rtl/core/pahag_pkg.sv
package pahag_pkg;

  // Operation codes
  localparam logic [1:0] OP_WRITE = 2'd0;
  localparam logic [1:0] OP_TOUCH = 2'd1;
  localparam logic [1:0] OP_SCAN  = 2'd2;

  // Configuration register indexes
  localparam logic CFG_TTL  = 1'b0;
  localparam logic CFG_BASE = 1'b1;

  // Field widths
  localparam int ID_W     = 6;
  localparam int MAX_IDS  = 1 << ID_W;
  localparam int TIME_W   = 32;
  localparam int EPOCH_W  = 16;
  localparam int TTL_W    = 16;
  localparam int BASE_W   = 10;
  localparam int CFG_W    = 16;
  localparam int CNT_W    = 6;
  localparam int SHED_W   = 4;
  localparam int SHTOT_W  = 10;
  localparam int CAP_W    = 11;
  localparam int GAP_W    = 12;

  // Stored entry layout: load one, load two, solar, shed count
  localparam int ENT_W     = 7;
  localparam int ENT_L1    = 6;
  localparam int ENT_L2    = 5;
  localparam int ENT_SOLAR = 4;

  // Capacity takes shed_total divided by four
  localparam int SHED_DIV_SHIFT = 2;

  typedef struct packed {
    logic wr_entry;
    logic wr_seen;
    logic scan_start;
    logic rd_en;
    logic calc;
  } ctrl_cmd_t;

  typedef struct packed {
    logic last_addr;
  } dp_stat_t;

endpackage

FILE: rtl/core/presence_aged_house_aggregator_top.sv
// Write and touch words leave busy low, so the next word can start at once.
// A recompute word keeps busy high while the scan walks the table, one table entry per cycle
// through the registered RAM read port; done pulses in the first cycle with busy low again.
// The receiver cannot stall: each result stands on the outputs from done until the next recompute ends.
// rst is synchronous, active high: clears valid bits, controller state, ttl=10, base=2.
`include "presence_aged_house_aggregator_top_defines.svh"

module presence_aged_house_aggregator_top import pahag_pkg::*; #(
  parameter int HOUSES = 64
) (
  input  logic                    clk,
  input  logic                    rst,
  // command side
  input  logic                    start,
  output logic                    busy,
  input  logic [1:0]              op,
  input  logic [ID_W-1:0]         house_id,
  input  logic                    load_one_on,
  input  logic                    load_two_on,
  input  logic                    has_solar,
  input  logic [SHED_W-1:0]       shed_count,
  input  logic [TIME_W-1:0]       now_seconds,
  input  logic [EPOCH_W-1:0]      grid_epoch,
  // configuration writes
  input  logic                    cfg_we,
  input  logic                    cfg_index,
  input  logic [CFG_W-1:0]        cfg_data,
  // result side
  output logic                    done,
  output logic [CNT_W-1:0]        active_houses,
  output logic [CNT_W-1:0]        solar_houses,
  output logic [SHTOT_W-1:0]      shed_total,
  output logic [CAP_W-1:0]        capacity,
  output logic signed [GAP_W-1:0] gap,
  output logic [EPOCH_W-1:0]      epoch_out
);

  ctrl_cmd_t cmd;
  dp_stat_t  stat;

  // Controller: take the word in idle, walk the table, then strobe the result.
  pahag_ctrl u_ctrl (
    .clk   (clk),
    .rst   (rst),
    .start (start),
    .op    (op),
    .stat  (stat),
    .cmd   (cmd),
    .busy  (busy)
  );

  // Datapath: entry and last-seen RAMs with per-entry valid bits, the
  // online test, the running sums and the capacity and gap math.
  pahag_dp #(.HOUSES(HOUSES)) u_dp (
    .clk           (clk),
    .rst           (rst),
    .cmd           (cmd),
    .stat          (stat),
    .house_id      (house_id),
    .load_one_on   (load_one_on),
    .load_two_on   (load_two_on),
    .has_solar     (has_solar),
    .shed_count    (shed_count),
    .now_seconds   (now_seconds),
    .grid_epoch    (grid_epoch),
    .cfg_we        (cfg_we),
    .cfg_index     (cfg_index),
    .cfg_data      (cfg_data),
    .done          (done),
    .active_houses (active_houses),
    .solar_houses  (solar_houses),
    .shed_total    (shed_total),
    .capacity      (capacity),
    .gap           (gap),
    .epoch_out     (epoch_out)
  );

  // A result only appears once the controller is back in idle.
  `PAHAG_ASSERT_IMPL(a_done_idle, clk, rst, done, !busy)
  // A recompute word must start the scan.
  `PAHAG_ASSERT_NEXT(a_scan_busy, clk, rst, start && !busy && (op == OP_SCAN), busy)
  // The final calc step produces exactly one strobe.
  `PAHAG_ASSERT_NEXT(a_calc_done, clk, rst, cmd.calc, done)
  `PAHAG_ASSERT_NEXT(a_done_pulse, clk, rst, done, !done)

endmodule

FILE: rtl/core/pahag_ram.sv
module pahag_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 64
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

FILE: rtl/core/pahag_ctrl.sv
module pahag_ctrl import pahag_pkg::*; (
  input  logic       clk,
  input  logic       rst,
  input  logic       start,
  input  logic [1:0] op,
  input  dp_stat_t   stat,
  output ctrl_cmd_t  cmd,
  output logic       busy
);

  typedef enum logic [3:0] {
    ST_IDLE  = 4'b0001,
    ST_READ  = 4'b0010,
    ST_DRAIN = 4'b0100,
    ST_CALC  = 4'b1000
  } state_t;

  state_t state, state_next;

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ST_IDLE;
    end else begin
      state <= state_next;
    end
  end

  always_comb begin
    state_next = state;
    cmd        = '0;
    unique case (state)
      ST_IDLE: begin
        if (start) begin
          cmd.wr_entry   = (op == OP_WRITE);
          cmd.wr_seen    = (op == OP_TOUCH);
          cmd.scan_start = (op == OP_SCAN);
          if (op == OP_SCAN) begin
            state_next = ST_READ;
          end
        end
      end
      ST_READ: begin
        cmd.rd_en = 1'b1;
        if (stat.last_addr) begin
          state_next = ST_DRAIN;
        end
      end
      ST_DRAIN: begin
        // last read word is summed here
        state_next = ST_CALC;
      end
      ST_CALC: begin
        cmd.calc   = 1'b1;
        state_next = ST_IDLE;
      end
      default: begin
        state_next = ST_IDLE;
      end
    endcase
  end

  assign busy = (state != ST_IDLE);

endmodule

FILE: rtl/core/pahag_dp.sv
module pahag_dp import pahag_pkg::*; #(
  parameter int HOUSES = 64
) (
  input  logic                      clk,
  input  logic                      rst,
  input  ctrl_cmd_t                 cmd,
  output dp_stat_t                  stat,
  input  logic [ID_W-1:0]           house_id,
  input  logic                      load_one_on,
  input  logic                      load_two_on,
  input  logic                      has_solar,
  input  logic [SHED_W-1:0]         shed_count,
  input  logic [TIME_W-1:0]         now_seconds,
  input  logic [EPOCH_W-1:0]        grid_epoch,
  input  logic                      cfg_we,
  input  logic                      cfg_index,
  input  logic [CFG_W-1:0]          cfg_data,
  output logic                      done,
  output logic [CNT_W-1:0]          active_houses,
  output logic [CNT_W-1:0]          solar_houses,
  output logic [SHTOT_W-1:0]        shed_total,
  output logic [CAP_W-1:0]          capacity,
  output logic signed [GAP_W-1:0]   gap,
  output logic [EPOCH_W-1:0]        epoch_out
);

  // only ids below MAX_IDS can ever be stored
  localparam int DEPTH = (HOUSES < MAX_IDS) ? HOUSES : MAX_IDS;
  localparam int AW    = $clog2(DEPTH);

  logic [TTL_W-1:0]   ttl;
  logic [BASE_W-1:0]  base;
  logic [DEPTH-1:0]   written_q;
  logic [DEPTH-1:0]   seen_q;
  logic [AW-1:0]      rd_addr;
  logic [AW-1:0]      wr_addr;
  logic               id_ok;
  logic               ent_we;
  logic               seen_we;
  logic [ENT_W-1:0]   ent_wdata;
  logic [ENT_W-1:0]   rd_ent;
  logic [TIME_W-1:0]  rd_time;
  logic               rd_pend;
  logic               rd_written;
  logic               rd_seen;
  logic [TIME_W-1:0]  now_q;
  logic [EPOCH_W-1:0] epoch_q;
  logic [CNT_W-1:0]   active_acc;
  logic [CNT_W-1:0]   solar_acc;
  logic [SHTOT_W-1:0] shed_acc;
  logic               online;
  logic [TIME_W-1:0]  elapsed;
  logic [CAP_W-1:0]   cap_calc;
  logic signed [GAP_W-1:0] gap_calc;

  always_ff @(posedge clk) begin
    if (rst) begin
      ttl  <= TTL_W'(10);
      base <= BASE_W'(2);
    end else if (cfg_we) begin
      unique case (cfg_index)
        CFG_TTL:  ttl  <= cfg_data[TTL_W-1:0];
        CFG_BASE: base <= cfg_data[BASE_W-1:0];
        default:  ;
      endcase
    end
  end

  assign id_ok     = (house_id != '0) && (int'(house_id) < HOUSES);
  assign wr_addr   = house_id[AW-1:0];
  assign ent_we    = cmd.wr_entry && id_ok;
  assign seen_we   = cmd.wr_seen && id_ok;
  assign ent_wdata = {load_one_on, load_two_on, has_solar, shed_count};

  pahag_ram #(.WIDTH(ENT_W), .DEPTH(DEPTH)) u_ent_ram (
    .clk   (clk),
    .we    (ent_we),
    .waddr (wr_addr),
    .wdata (ent_wdata),
    .raddr (rd_addr),
    .rdata (rd_ent)
  );

  pahag_ram #(.WIDTH(TIME_W), .DEPTH(DEPTH)) u_time_ram (
    .clk   (clk),
    .we    (seen_we),
    .waddr (wr_addr),
    .wdata (now_seconds),
    .raddr (rd_addr),
    .rdata (rd_time)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      written_q <= '0;
      seen_q    <= '0;
      rd_pend   <= 1'b0;
      done      <= 1'b0;
    end else begin
      if (ent_we) begin
        written_q[wr_addr] <= 1'b1;
      end
      if (seen_we) begin
        seen_q[wr_addr] <= 1'b1;
      end
      rd_pend <= cmd.rd_en;
      done    <= cmd.calc;
    end
  end

  // scan address; valid bits are registered alongside the RAM read so they line up with its data
  always_ff @(posedge clk) begin
    if (cmd.scan_start) begin
      rd_addr <= AW'(1);
      now_q   <= now_seconds;
      epoch_q <= grid_epoch;
    end else if (cmd.rd_en) begin
      rd_addr <= rd_addr + AW'(1);
    end
    rd_written <= written_q[rd_addr];
    rd_seen    <= seen_q[rd_addr];
  end

  assign stat.last_addr = (rd_addr == AW'(DEPTH - 1));

  assign elapsed = now_q - rd_time;
  assign online  = rd_written && rd_seen && (rd_time != '0) &&
                   ((now_q < rd_time) || (elapsed <= TIME_W'(ttl)));

  always_ff @(posedge clk) begin
    if (cmd.scan_start) begin
      active_acc <= '0;
      solar_acc  <= '0;
      shed_acc   <= '0;
    end else if (rd_pend && online) begin
      active_acc <= active_acc + CNT_W'(rd_ent[ENT_L1] | rd_ent[ENT_L2]);
      solar_acc  <= solar_acc + CNT_W'(rd_ent[ENT_SOLAR]);
      shed_acc   <= shed_acc + SHTOT_W'(rd_ent[SHED_W-1:0]);
    end
  end

  assign cap_calc = CAP_W'(base) + CAP_W'(solar_acc) +
                    CAP_W'(shed_acc >> SHED_DIV_SHIFT);
  assign gap_calc = $signed(GAP_W'(active_acc)) - $signed(GAP_W'(cap_calc));

  always_ff @(posedge clk) begin
    if (cmd.calc) begin
      active_houses <= active_acc;
      solar_houses  <= solar_acc;
      shed_total    <= shed_acc;
      capacity      <= cap_calc;
      gap           <= gap_calc;
      epoch_out     <= epoch_q;
    end
  end

endmodule
